### design/block_buffer_cache_lru_macros.svh
// assertion macros for the block buffer cache tag controller
// used by the port checker; expects clk and rst in the calling scope
`ifndef BLOCK_BUFFER_CACHE_LRU_MACROS_SVH
`define BLOCK_BUFFER_CACHE_LRU_MACROS_SVH

// same-cycle implication
`define BBC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define BBC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### design/bbc_pkg.sv
// shared types and codes for the block buffer cache tag controller
// no dependencies
`timescale 1ns / 1ps

package bbc_pkg;

  typedef logic [2:0] opcode_t;
  typedef logic [1:0] disk_cmd_t;
  typedef logic [1:0] status_t;

  localparam opcode_t OP_GET     = 3'd0;
  localparam opcode_t OP_READ    = 3'd1;
  localparam opcode_t OP_RELEASE = 3'd2;
  localparam opcode_t OP_WRITE   = 3'd3;
  localparam opcode_t OP_DWRITE  = 3'd4;
  localparam opcode_t OP_FLUSH   = 3'd5;

  localparam disk_cmd_t CMD_NONE  = 2'd0;
  localparam disk_cmd_t CMD_READ  = 2'd1;
  localparam disk_cmd_t CMD_WRITE = 2'd2;

  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_NOFREE = 2'd1;
  localparam status_t ST_FREED  = 2'd2;

  localparam int IDX_BITS = 4;

  typedef struct packed {
    logic      hit;
    disk_cmd_t cmd;
    status_t   status;
    logic      last;
  } res_ctrl_t;

endpackage

### design/bbc_queue.sv
// two-entry word queue between the front and back parts
// no package dependencies
`timescale 1ns / 1ps

module bbc_queue #(
  parameter int W = 31
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         full,
  output logic         empty
);

  logic [W-1:0] slot [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   fill;

  assign full     = (fill == 2'd2);
  assign empty    = (fill == 2'd0);
  assign pop_data = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

### design/bbc_front.sv
// front part: accepts request words, drops ignored ones, packs the rest
// depends on bbc_pkg
`timescale 1ns / 1ps

module bbc_front #(
  parameter int NUM_BUFFERS = 16,
  parameter int BLOCK_BITS  = 24
) (
  input  logic                      in_valid,
  output logic                      in_stall,
  input  bbc_pkg::opcode_t          opcode,
  input  logic [BLOCK_BITS-1:0]     block_number,
  input  logic [bbc_pkg::IDX_BITS-1:0] buffer_index,
  input  logic                      q_full,
  output logic                      q_push,
  output logic [3+bbc_pkg::IDX_BITS+BLOCK_BITS-1:0] q_data
);
  import bbc_pkg::*;

  logic idx_ok;
  logic keep;

  assign idx_ok = (32'(buffer_index) < 32'(NUM_BUFFERS));

  always_comb begin
    case (opcode)
      OP_GET, OP_READ, OP_FLUSH:       keep = 1'b1;
      OP_RELEASE, OP_WRITE, OP_DWRITE: keep = idx_ok;
      default:                         keep = 1'b0;
    endcase
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full && keep;
  assign q_data   = {opcode, buffer_index, block_number};

endmodule

### design/bbc_back.sv
// back part: tag match, lru list, flag updates and result word register
// depends on bbc_pkg
`timescale 1ns / 1ps

module bbc_back #(
  parameter int NUM_BUFFERS = 16,
  parameter int BLOCK_BITS  = 24
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_empty,
  input  logic [3+bbc_pkg::IDX_BITS+BLOCK_BITS-1:0] q_data,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [bbc_pkg::IDX_BITS-1:0] granted_buffer,
  output logic                      hit,
  output bbc_pkg::disk_cmd_t        disk_command,
  output logic [BLOCK_BITS-1:0]     disk_block,
  output bbc_pkg::status_t          status,
  output logic                      last
);
  import bbc_pkg::*;

  localparam int IW = $clog2(NUM_BUFFERS);
  localparam int LW = $clog2(NUM_BUFFERS + 1);
  localparam logic [LW-1:0] NIL = LW'(NUM_BUFFERS);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_READ  = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  logic [1:0]            state;
  logic [NUM_BUFFERS-1:0] valid_bits;
  logic [NUM_BUFFERS-1:0] dirty;
  logic [NUM_BUFFERS-1:0] done;
  logic [NUM_BUFFERS-1:0] on_list;
  logic [BLOCK_BITS-1:0] tag [NUM_BUFFERS];
  logic [LW-1:0]         link_tail [NUM_BUFFERS];
  logic [LW-1:0]         link_head [NUM_BUFFERS];
  logic [LW-1:0]         head;
  logic [LW-1:0]         tail;
  logic [LW-1:0]         count;

  opcode_t               cur_op;
  logic [IW-1:0]         cur_idx;
  logic [BLOCK_BITS-1:0] cur_blk;
  logic [IW-1:0]         sel;

  logic                  out_free;
  logic                  found;
  logic [IW-1:0]         m;
  logic                  hd;
  logic                  have_free;
  logic [IW-1:0]         vic;
  logic                  un_en;
  logic [IW-1:0]         un_idx;
  logic [LW-1:0]         un_p;
  logic [LW-1:0]         un_nx;

  logic                  em_valid;
  logic [IW-1:0]         em_buf;
  logic [BLOCK_BITS-1:0] em_blk;
  res_ctrl_t             em_ctrl;

  assign out_free  = !out_valid || !out_stall;
  assign q_pop     = (state == S_IDLE) && !q_empty;
  assign have_free = (count != '0) && (head < NIL);
  assign vic       = head[IW-1:0];

  always_comb begin
    found = 1'b0;
    m     = '0;
    for (int k = NUM_BUFFERS - 1; k >= 0; k--) begin
      if (valid_bits[k] && (tag[k] == cur_blk)) begin
        found = 1'b1;
        m     = IW'(k);
      end
    end
  end

  always_comb begin
    hd = 1'b0;
    for (int k = 0; k < NUM_BUFFERS; k++) begin
      if (dirty[k] && (IW'(k) > sel)) hd = 1'b1;
    end
  end

  assign un_en  = (state == S_EXEC) && out_free
                  && ((cur_op == OP_GET) || (cur_op == OP_READ))
                  && (found ? on_list[m] : have_free);
  assign un_idx = found ? m : vic;
  assign un_p   = link_head[un_idx];
  assign un_nx  = link_tail[un_idx];

  always_comb begin
    em_valid = 1'b0;
    em_buf   = '0;
    em_blk   = '0;
    em_ctrl  = '{hit: 1'b0, cmd: CMD_NONE, status: ST_OK, last: 1'b0};
    case (state)
      S_EXEC: begin
        if (out_free) begin
          case (cur_op)
            OP_GET, OP_READ: begin
              if (found) begin
                if ((cur_op == OP_GET) || done[m]) begin
                  em_valid     = 1'b1;
                  em_buf       = m;
                  em_ctrl.hit  = 1'b1;
                  em_ctrl.last = 1'b1;
                end
              end else if (!have_free) begin
                em_valid       = 1'b1;
                em_ctrl.status = ST_NOFREE;
                em_ctrl.last   = 1'b1;
              end else if (dirty[vic]) begin
                em_valid     = 1'b1;
                em_buf       = vic;
                em_ctrl.cmd  = CMD_WRITE;
                em_blk       = tag[vic];
                em_ctrl.last = (cur_op == OP_GET);
              end else if (cur_op == OP_GET) begin
                em_valid     = 1'b1;
                em_buf       = vic;
                em_ctrl.last = 1'b1;
              end
            end
            OP_RELEASE, OP_WRITE, OP_DWRITE: begin
              em_valid       = 1'b1;
              em_buf         = cur_idx;
              em_ctrl.status = on_list[cur_idx] ? ST_FREED : ST_OK;
              em_ctrl.last   = 1'b1;
              if (cur_op == OP_WRITE) begin
                em_ctrl.cmd = CMD_WRITE;
                em_blk      = tag[cur_idx];
              end
            end
            OP_FLUSH: begin
              if (dirty == '0) begin
                em_valid     = 1'b1;
                em_ctrl.last = 1'b1;
              end
            end
            default: em_valid = 1'b0;
          endcase
        end
      end
      S_READ: begin
        if (out_free) begin
          em_valid     = 1'b1;
          em_buf       = sel;
          em_ctrl.cmd  = CMD_READ;
          em_blk       = cur_blk;
          em_ctrl.last = 1'b1;
        end
      end
      S_FLUSH: begin
        if (out_free && dirty[sel]) begin
          em_valid     = 1'b1;
          em_buf       = sel;
          em_ctrl.cmd  = CMD_WRITE;
          em_blk       = tag[sel];
          em_ctrl.last = !hd;
        end
      end
      default: em_valid = 1'b0;
    endcase
  end

  // result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (em_valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (em_valid) begin
      granted_buffer <= IDX_BITS'(em_buf);
      hit            <= em_ctrl.hit;
      disk_command   <= em_ctrl.cmd;
      disk_block     <= em_blk;
      status         <= em_ctrl.status;
      last           <= em_ctrl.last;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_op  <= q_data[3+IDX_BITS+BLOCK_BITS-1 -: 3];
      cur_idx <= IW'(q_data[IDX_BITS+BLOCK_BITS-1 -: IDX_BITS]);
      cur_blk <= q_data[BLOCK_BITS-1:0];
    end
    if ((state == S_EXEC) && out_free && !found && have_free
        && ((cur_op == OP_GET) || (cur_op == OP_READ))) begin
      tag[vic] <= cur_blk;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      sel        <= '0;
      valid_bits <= '0;
      dirty      <= '0;
      done       <= '0;
      on_list    <= '1;
      head       <= '0;
      tail       <= LW'(NUM_BUFFERS - 1);
      count      <= LW'(NUM_BUFFERS);
      for (int i = 0; i < NUM_BUFFERS; i++) begin
        link_tail[i] <= LW'(i + 1);
        link_head[i] <= (i == 0) ? NIL : LW'(i - 1);
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (q_pop) state <= S_EXEC;
        end
        S_EXEC: begin
          if (out_free) begin
            case (cur_op)
              OP_GET, OP_READ: begin
                if (found) begin
                  if ((cur_op == OP_GET) || done[m]) begin
                    state <= S_IDLE;
                  end else begin
                    sel   <= m;
                    state <= S_READ;
                  end
                end else if (!have_free) begin
                  state <= S_IDLE;
                end else begin
                  dirty[vic]      <= 1'b0;
                  done[vic]       <= 1'b0;
                  valid_bits[vic] <= 1'b1;
                  sel             <= vic;
                  state           <= (cur_op == OP_READ) ? S_READ : S_IDLE;
                end
              end
              OP_RELEASE, OP_WRITE, OP_DWRITE: begin
                if (cur_op == OP_WRITE) begin
                  dirty[cur_idx] <= 1'b0;
                  done[cur_idx]  <= 1'b1;
                end else if (cur_op == OP_DWRITE) begin
                  dirty[cur_idx] <= 1'b1;
                  done[cur_idx]  <= 1'b1;
                end
                if (!on_list[cur_idx]) begin
                  link_head[cur_idx] <= (count != '0) ? tail : NIL;
                  link_tail[cur_idx] <= NIL;
                  if (count == '0) begin
                    head <= LW'(cur_idx);
                  end else if (tail < NIL) begin
                    link_tail[tail[IW-1:0]] <= LW'(cur_idx);
                  end
                  tail             <= LW'(cur_idx);
                  count            <= count + 1'b1;
                  on_list[cur_idx] <= 1'b1;
                end
                state <= S_IDLE;
              end
              OP_FLUSH: begin
                sel   <= '0;
                state <= (dirty == '0) ? S_IDLE : S_FLUSH;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_READ: begin
          if (out_free) begin
            done[sel] <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_FLUSH: begin
          if (!dirty[sel]) begin
            sel <= sel + 1'b1;
          end else if (out_free) begin
            dirty[sel] <= 1'b0;
            done[sel]  <= 1'b1;
            if (hd) begin
              sel <= sel + 1'b1;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase

      // list unlink for a get or read
      if (un_en) begin
        if (LW'(un_idx) == head) begin
          head <= un_nx;
        end else if (un_p < NIL) begin
          link_tail[un_p[IW-1:0]] <= un_nx;
        end
        if (LW'(un_idx) == tail) begin
          tail <= un_p;
        end else if (un_nx < NIL) begin
          link_head[un_nx[IW-1:0]] <= un_p;
        end
        link_head[un_idx] <= NIL;
        link_tail[un_idx] <= NIL;
        on_list[un_idx]   <= 1'b0;
        if (count != '0) count <= count - 1'b1;
      end
    end
  end

endmodule

### design/block_buffer_cache_lru.sv
// channel  | handshake            | fields
// input    | in_valid / in_stall   | opcode, block_number, buffer_index
// result   | out_valid / out_stall | granted_buffer, hit, disk_command, disk_block,
//          |                       | status, last
//
// get, release, write and delayed write pass from the queue through the idle and exec states
// to the result word register; a read that fetches goes on through the read state; flush
// walks the dirty flags in index order up to the highest dirty one, one word per dirty buffer.
// a two-entry queue takes requests while the back part works; no clearing pass.
// rst is synchronous, empties the queue and the result register, puts every buffer on the lru list.
// a stalled result word holds, and the back part waits on it.
// top level of the block buffer cache tag controller; depends on bbc_pkg,
// bbc_front, bbc_queue and bbc_back
`timescale 1ns / 1ps

module block_buffer_cache_lru #(
  parameter int NUM_BUFFERS = 16,
  parameter int BLOCK_BITS  = 24
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  bbc_pkg::opcode_t          opcode,
  input  logic [BLOCK_BITS-1:0]     block_number,
  input  logic [bbc_pkg::IDX_BITS-1:0] buffer_index,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [bbc_pkg::IDX_BITS-1:0] granted_buffer,
  output logic                      hit,
  output bbc_pkg::disk_cmd_t        disk_command,
  output logic [BLOCK_BITS-1:0]     disk_block,
  output bbc_pkg::status_t          status,
  output logic                      last
);
  import bbc_pkg::*;

  localparam int QW = 3 + IDX_BITS + BLOCK_BITS;

  logic          q_full;
  logic          q_empty;
  logic          q_push;
  logic          q_pop;
  logic [QW-1:0] q_in;
  logic [QW-1:0] q_out;

  bbc_front #(
    .NUM_BUFFERS(NUM_BUFFERS),
    .BLOCK_BITS (BLOCK_BITS)
  ) u_front (
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .opcode      (opcode),
    .block_number(block_number),
    .buffer_index(buffer_index),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_in)
  );

  bbc_queue #(
    .W(QW)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(q_in),
    .pop      (q_pop),
    .pop_data (q_out),
    .full     (q_full),
    .empty    (q_empty)
  );

  bbc_back #(
    .NUM_BUFFERS(NUM_BUFFERS),
    .BLOCK_BITS (BLOCK_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_data        (q_out),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .granted_buffer(granted_buffer),
    .hit           (hit),
    .disk_command  (disk_command),
    .disk_block    (disk_block),
    .status        (status),
    .last          (last)
  );

endmodule

### design/bbc_checker.sv
// port checker for the block buffer cache tag controller, bound to the top
// depends on bbc_pkg and block_buffer_cache_lru_macros.svh
`timescale 1ns / 1ps
`include "block_buffer_cache_lru_macros.svh"

module bbc_checker #(
  parameter int BLOCK_BITS = 24
) (
  input logic                      clk,
  input logic                      rst,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [bbc_pkg::IDX_BITS-1:0] granted_buffer,
  input logic                      hit,
  input bbc_pkg::disk_cmd_t        disk_command,
  input logic [BLOCK_BITS-1:0]     disk_block,
  input bbc_pkg::status_t          status,
  input logic                      last
);
  import bbc_pkg::*;

  `BBC_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(granted_buffer))
  `BBC_ASSERT_IMP(a_nofree, out_valid && (status == ST_NOFREE),
    last && (granted_buffer == '0) && (disk_command == CMD_NONE))
  `BBC_ASSERT_IMP(a_hit, out_valid && hit,
    last && (disk_command == CMD_NONE) && (status == ST_OK))
  `BBC_ASSERT_IMP(a_noblk, out_valid && (disk_command == CMD_NONE), disk_block == '0)

endmodule

bind block_buffer_cache_lru bbc_checker #(.BLOCK_BITS(BLOCK_BITS)) u_bbc_checker (.*);

### dv/tb_block_buffer_cache_lru.sv
// self-checking testbench for the block buffer cache tag controller
// predicts result words from its own copy of tags, marks and lru list;
// depends on bbc_pkg and block_buffer_cache_lru
`timescale 1ns / 1ps

module tb_block_buffer_cache_lru;
  import bbc_pkg::*;

  localparam int NB = 16;
  localparam int BB = 24;
  localparam int WATCHDOG = 4000;

  typedef struct packed {
    logic [3:0]    gb;
    logic          hit;
    disk_cmd_t     cmd;
    logic [BB-1:0] blk;
    status_t       st;
    logic          last;
  } word_t;

  typedef struct {
    opcode_t       op;
    logic [BB-1:0] blk;
    logic [3:0]    bi;
    int            nwords;
    bit            hold;
  } req_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  opcode_t opcode = OP_GET;
  logic [BB-1:0] block_number = '0;
  logic [3:0] buffer_index = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [3:0] granted_buffer;
  logic hit;
  disk_cmd_t disk_command;
  logic [BB-1:0] disk_block;
  status_t status;
  logic last;

  block_buffer_cache_lru dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .block_number(block_number), .buffer_index(buffer_index),
    .out_valid(out_valid), .out_stall(out_stall),
    .granted_buffer(granted_buffer), .hit(hit), .disk_command(disk_command),
    .disk_block(disk_block), .status(status), .last(last)
  );

  always #2 clk = ~clk;

  // shadow cache state
  bit            m_valid [NB];
  bit            m_dirty [NB];
  bit            m_done  [NB];
  bit            m_onlist[NB];
  logic [BB-1:0] m_tag   [NB];
  int            m_next  [NB];
  int            m_prev  [NB];
  int            m_head, m_tail, m_count;

  req_t  pending_reqs[$];
  word_t expected_words[$];
  word_t new_words[$];
  logic [BB-1:0] block_pool[$];

  int sent_words = 0;
  int got_words = 0;
  int fails = 0;
  int quiet_cycles = 0;
  int in_gap = 0;
  int out_gap = 0;
  bit no_idle = 0;

  function automatic void put_word(int gb, bit h, disk_cmd_t c, logic [BB-1:0] b,
                                   status_t s);
    word_t w;
    w.gb = gb[3:0];
    w.hit = h;
    w.cmd = c;
    w.blk = (c == CMD_NONE) ? '0 : b;
    w.st = s;
    w.last = 0;
    new_words.push_back(w);
  endfunction

  function automatic void unlink(int i);
    int p, nx;
    p = m_prev[i];
    nx = m_next[i];
    if (i == m_head) m_head = nx; else if (p < NB) m_next[p] = nx;
    if (i == m_tail) m_tail = p; else if (nx < NB) m_prev[nx] = p;
    m_prev[i] = NB;
    m_next[i] = NB;
    m_onlist[i] = 0;
    if (m_count > 0) m_count--;
  endfunction

  function automatic status_t append(int i);
    if (m_onlist[i]) return ST_FREED;
    m_prev[i] = m_count ? m_tail : NB;
    m_next[i] = NB;
    if (m_count == 0) m_head = i;
    else if (m_tail < NB) m_next[m_tail] = i;
    m_tail = i;
    m_count++;
    m_onlist[i] = 1;
    return ST_OK;
  endfunction

  function automatic int lookup(logic [BB-1:0] b, bit is_read);
    int v;
    for (int i = 0; i < NB; i++) begin
      if (m_valid[i] && m_tag[i] == b) begin
        if (m_onlist[i]) unlink(i);
        if (!is_read || m_done[i]) put_word(i, 1, CMD_NONE, 0, ST_OK);
        return i;
      end
    end
    if (m_count == 0 || m_head >= NB) begin
      put_word(0, 0, CMD_NONE, 0, ST_NOFREE);
      return -1;
    end
    v = m_head;
    unlink(v);
    if (m_dirty[v]) put_word(v, 0, CMD_WRITE, m_tag[v], ST_OK);
    else if (!is_read) put_word(v, 0, CMD_NONE, 0, ST_OK);
    m_dirty[v] = 0;
    m_done[v] = 0;
    m_valid[v] = 1;
    m_tag[v] = b;
    return v;
  endfunction

  // apply one request to the shadow state and queue its words
  function automatic void add_req(opcode_t op, logic [BB-1:0] b, logic [3:0] bi, bit hold);
    req_t r;
    int g;
    status_t s;
    new_words.delete();
    case (op)
      OP_GET: g = lookup(b, 0);
      OP_READ: begin
        g = lookup(b, 1);
        if (g >= 0 && !m_done[g]) begin
          put_word(g, 0, CMD_READ, b, ST_OK);
          m_done[g] = 1;
        end
      end
      OP_RELEASE: begin
        s = append(bi);
        put_word(bi, 0, CMD_NONE, 0, s);
      end
      OP_WRITE: begin
        m_dirty[bi] = 0;
        m_done[bi] = 1;
        s = append(bi);
        put_word(bi, 0, CMD_WRITE, m_tag[bi], s);
      end
      OP_DWRITE: begin
        m_dirty[bi] = 1;
        m_done[bi] = 1;
        s = append(bi);
        put_word(bi, 0, CMD_NONE, 0, s);
      end
      OP_FLUSH: begin
        for (int i = 0; i < NB; i++) begin
          if (m_dirty[i]) begin
            m_dirty[i] = 0;
            m_done[i] = 1;
            put_word(i, 0, CMD_WRITE, m_tag[i], ST_OK);
          end
        end
        if (new_words.size() == 0) put_word(0, 0, CMD_NONE, 0, ST_OK);
      end
      default: ;
    endcase
    if (new_words.size() > 0) new_words[new_words.size()-1].last = 1;
    foreach (new_words[k]) expected_words.push_back(new_words[k]);
    r.op = op;
    r.blk = b;
    r.bi = bi;
    r.nwords = new_words.size();
    r.hold = hold;
    pending_reqs.push_back(r);
  endfunction

  // tagged buffer, preferring ones held off the free list
  function automatic int pick_tagged();
    int c[$];
    for (int i = 0; i < NB; i++) if (m_valid[i] && !m_onlist[i]) c.push_back(i);
    if (c.size() == 0 || $urandom_range(0, 4) == 0)
      for (int i = 0; i < NB; i++) if (m_valid[i]) c.push_back(i);
    if (c.size() == 0) return -1;
    return c[$urandom_range(0, c.size()-1)];
  endfunction

  function automatic void add_random(bit hold);
    int k, t;
    logic [BB-1:0] b;
    logic [3:0] bi;
    k = $urandom_range(0, 99);
    b = $urandom_range(0, 3) == 0 ? BB'($urandom) : block_pool[$urandom_range(0, 23)];
    bi = 4'($urandom);
    t = pick_tagged();
    if (k < 25) add_req(OP_GET, b, bi, hold);
    else if (k < 45) add_req(OP_READ, b, bi, hold);
    else if (k < 60) add_req(OP_RELEASE, BB'($urandom), (t >= 0 && k < 56) ? 4'(t) : bi, hold);
    else if (k < 72 && t >= 0) add_req(OP_DWRITE, BB'($urandom), 4'(t), hold);
    else if (k < 82 && t >= 0) add_req(OP_WRITE, BB'($urandom), 4'(t), hold);
    else if (k < 90) add_req(OP_FLUSH, BB'($urandom), bi, hold);
    else if (k < 94) add_req(opcode_t'($urandom_range(6, 7)), b, bi, hold);
    else add_req(OP_RELEASE, b, bi, hold);
  endfunction

  // driver
  always @(posedge clk) begin
    bit fire;
    req_t r;
    if (rst) begin
      in_valid <= 0;
    end else begin
      fire = in_valid && !in_stall;
      if (fire) sent_words <= sent_words + pending_reqs[0].nwords;
      if (fire) pending_reqs.pop_front();
      if (!in_valid || fire) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 0;
        end else if (pending_reqs.size() == 0) begin
          in_valid <= 0;
        end else if (pending_reqs[0].hold &&
                     sent_words + (fire ? r.nwords : 0) != got_words) begin
          in_valid <= 0;
        end else if (!no_idle && $urandom_range(0, 5) == 0) begin
          in_gap <= $urandom_range(0, 6);
          in_valid <= 0;
        end else begin
          pending_reqs[0].hold = 0;
          r = pending_reqs[0];
          opcode <= r.op;
          block_number <= r.blk;
          buffer_index <= r.bi;
          in_valid <= 1;
        end
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    word_t w, e;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got_words <= got_words + 1;
        w = '{granted_buffer, hit, disk_command, disk_block, status, last};
        if (expected_words.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result word %p", w);
        end else begin
          e = expected_words.pop_front();
          if (w !== e) begin
            fails++;
            if (fails <= 10) $display("mismatch: expected %p actual %p", e, w);
          end
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall <= 1;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        out_gap <= $urandom_range(0, 6);
        out_stall <= 1;
      end else begin
        out_stall <= 0;
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
        $display("block_buffer_cache_lru test failed");
        $finish;
      end
    end
  end

  initial begin
    int t;
    for (int i = 0; i < NB; i++) begin
      m_valid[i] = 0;
      m_dirty[i] = 0;
      m_done[i] = 0;
      m_onlist[i] = 1;
      m_tag[i] = '0;
      m_next[i] = i + 1;
      m_prev[i] = (i == 0) ? NB : i - 1;
    end
    m_head = 0;
    m_tail = NB - 1;
    m_count = NB;
    block_pool.push_back('0);
    block_pool.push_back('1);
    for (int i = 2; i < 24; i++) block_pool.push_back(BB'($urandom));

    // directed
    add_req(OP_FLUSH, '0, '0, 0);
    add_req(OP_GET, '0, 4'hf, 0);
    add_req(OP_READ, '0, 4'hf, 0);
    add_req(OP_READ, '1, '0, 0);
    add_req(OP_READ, '1, '0, 0);
    add_req(OP_DWRITE, '0, 4'd0, 0);
    add_req(OP_RELEASE, '1, 4'd5, 0);
    add_req(OP_WRITE, '1, 4'd1, 0);
    add_req(OP_RELEASE, '0, 4'd1, 0);
    for (int i = 0; i < 15; i++) add_req(OP_GET, BB'(24'h100 + i), 4'($urandom), 0);
    add_req(OP_GET, 24'h800000, '0, 0);
    add_req(OP_READ, 24'h7fffff, '1, 0);
    add_req(opcode_t'(7), '1, '1, 0);
    add_req(opcode_t'(6), '0, '0, 0);
    for (int i = 0; i < NB; i++) add_req(OP_DWRITE, '0, 4'(i), 0);
    add_req(OP_FLUSH, '1, '1, 1);
    add_req(OP_GET, 24'h555555, '0, 0);

    for (int i = 0; i < 500; i++) add_random(i % 100 == 50);

    repeat (4) @(posedge clk);
    rst <= 0;
    wait (pending_reqs.size() <= 60);
    no_idle = 1;
    t = 0;
    while ((pending_reqs.size() != 0 || expected_words.size() != 0) && t < 200000) begin
      @(posedge clk);
      t++;
    end
    repeat (40) @(posedge clk);
    if (fails == 0 && t < 200000 && expected_words.size() == 0)
      $display("block_buffer_cache_lru test passed");
    else
      $display("block_buffer_cache_lru test failed");
    $finish;
  end

endmodule
